### sv/recycling_id_allocator_defines.svh
// ----------------------------------------------------------------------------
// recycling id allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef RECYCLING_ID_ALLOCATOR_DEFINES_SVH
`define RECYCLING_ID_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define RID_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("recycling_id_allocator assertion failed");

// property checked on every clock edge, reset included
`define RID_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("recycling_id_allocator assertion failed");

`else

`define RID_ASSERT(name, clk, rst, prop)
`define RID_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

### sv/rid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_pkg
// shared constants and request codes of the recycling id allocator
// ----------------------------------------------------------------------------
package rid_pkg;

   // default sizing
   localparam int ID_COUNT_DEF    = 1024;
   localparam int HANDLE_BITS_DEF = 32;

   // fixed field widths
   localparam int ID_W     = 10;
   localparam int HANDLE_W = 32;
   localparam int REQ_W    = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

endpackage

### sv/recycling_id_allocator.sv
// flow: a request transfer issues the registered read of the handle map and
//   recycle stack rams, and the ST_EXEC state then does the update and
//   registers the response; a new request is taken only in ST_IDLE
// reset: synchronous; afterwards the handle map is cleared one entry a cycle,
//   all ID_COUNT entries, with req_ready low until the pass completes
`timescale 1ns / 1ps
`include "recycling_id_allocator_defines.svh"
// ----------------------------------------------------------------------------
// recycling_id_allocator
// hands out small stable ids bound to entry handles, recycling released ids
// through a lifo stack, with an id to handle map held in ram
// ----------------------------------------------------------------------------
module recycling_id_allocator #(
   parameter int ID_COUNT    = rid_pkg::ID_COUNT_DEF,
   parameter int HANDLE_BITS = rid_pkg::HANDLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rid_pkg::REQ_W-1:0]    req_type,
   input  logic [rid_pkg::HANDLE_W-1:0] req_entry_handle,
   input  logic [rid_pkg::ID_W-1:0]     req_word_id,
   input  logic                         req_id_present,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rid_pkg::ID_W-1:0]     rsp_result_id,
   output logic                         rsp_id_ok,
   output logic [rid_pkg::HANDLE_W-1:0] rsp_result_handle
);

   localparam int ADDR_W = $clog2(ID_COUNT);
   localparam int CNT_W  = $clog2(ID_COUNT + 1);
   localparam int MAP_W  = (HANDLE_BITS < rid_pkg::HANDLE_W) ? HANDLE_BITS
                                                             : rid_pkg::HANDLE_W;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   // control registers
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [rid_pkg::REQ_W-1:0] op_ff, op_in;
   logic [MAP_W-1:0]          handle_ff, handle_in;
   logic [rid_pkg::ID_W-1:0]  id_ff, id_in;
   logic                      present_ff, present_in;

   // response registers
   logic [rid_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [rid_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   // ram ports
   logic                     map_wr_en, map_rd_en;
   logic [ADDR_W-1:0]        map_wr_addr, map_rd_addr;
   logic [MAP_W-1:0]         map_wr_data, map_rd_data;
   logic                     stk_wr_en, stk_rd_en;
   logic [ADDR_W-1:0]        stk_wr_addr, stk_rd_addr;
   logic [rid_pkg::ID_W-1:0] stk_rd_data;

   logic              req_xfer;
   logic              id_in_range;
   logic [ADDR_W-1:0] grant_id;

   // id to handle map
   rid_ram #(
      .WIDTH (MAP_W),
      .DEPTH (ID_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // recycle stack of released ids
   rid_ram #(
      .WIDTH (rid_pkg::ID_W),
      .DEPTH (ID_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (id_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // handshake
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   assign id_in_range = (32'(id_ff) < 32'(ID_COUNT));

   // read issue on request transfer, read-modify-write in the following ST_EXEC cycle
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      op_in         = op_ff;
      handle_in     = handle_ff;
      id_in         = id_ff;
      present_in    = present_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_handle_in = rsp_handle_ff;
      map_wr_en     = 1'b0;
      map_wr_addr   = clr_ff;
      map_wr_data   = '0;
      map_rd_en     = 1'b0;
      map_rd_addr   = ADDR_W'(req_word_id);
      stk_wr_en     = 1'b0;
      stk_wr_addr   = free_count_ff[ADDR_W-1:0];
      stk_rd_en     = 1'b0;
      stk_rd_addr   = ADDR_W'(free_count_ff - CNT_W'(1));
      grant_id      = '0;

      case (state_ff)
         ST_CLEAR: begin
            // zero the handle map after reset
            map_wr_en = 1'b1;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(ID_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in      = req_type;
               handle_in  = MAP_W'(req_entry_handle);
               id_in      = req_word_id;
               present_in = req_id_present;
               map_rd_en  = 1'b1;
               stk_rd_en  = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_id_in     = '0;
            rsp_ok_in     = 1'b0;
            rsp_handle_in = '0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
            case (op_ff)
               rid_pkg::REQ_ALLOC: begin
                  if (handle_ff != '0) begin
                     // recycled id first, then a fresh one
                     if (free_count_ff != '0) begin
                        grant_id      = ADDR_W'(stk_rd_data);
                        free_count_in = free_count_ff - CNT_W'(1);
                        map_wr_en     = 1'b1;
                     end else if (fresh_ff < CNT_W'(ID_COUNT)) begin
                        grant_id  = ADDR_W'(fresh_ff);
                        fresh_in  = fresh_ff + CNT_W'(1);
                        map_wr_en = 1'b1;
                     end
                     map_wr_addr = grant_id;
                     map_wr_data = handle_ff;
                     rsp_id_in   = rid_pkg::ID_W'(grant_id);
                     rsp_ok_in   = map_wr_en;
                  end
               end
               rid_pkg::REQ_RELEASE: begin
                  if (handle_ff != '0 && present_ff && id_in_range) begin
                     // clear the map only if the releasing handle still owns it
                     map_wr_addr = ADDR_W'(id_ff);
                     map_wr_en   = (map_rd_data == handle_ff);
                     // push unless the stack is full
                     if (free_count_ff < CNT_W'(ID_COUNT)) begin
                        stk_wr_en     = 1'b1;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                     rsp_ok_in = 1'b1;
                  end
               end
               rid_pkg::REQ_LOOKUP: begin
                  if (id_in_range) begin
                     rsp_handle_in = rid_pkg::HANDLE_W'(map_rd_data);
                     rsp_ok_in     = (map_rd_data != '0);
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      id_ff         <= id_in;
      present_ff    <= present_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_id_ok         = rsp_ok_ff;
   assign rsp_result_handle = rsp_handle_ff;

   // checks
   `RID_ASSERT(a_free_count_bound, clock, reset, free_count_ff <= CNT_W'(ID_COUNT))
   `RID_ASSERT(a_fresh_bound, clock, reset, fresh_ff <= CNT_W'(ID_COUNT))
   `RID_ASSERT(a_xfer_to_exec, clock, reset, req_xfer |=> (state_ff == ST_EXEC))
   `RID_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))

endmodule

### sv/rid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/rid_grant_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_grant_checker
// watches both channels of the recycling id allocator, predicts the response
// of every accepted request from its own copy of the id map and recycle
// stack, and compares responses field by field in transfer order
// ----------------------------------------------------------------------------
module rid_grant_checker
   import rid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [HANDLE_W-1:0] req_entry_handle,
   input  logic [ID_W-1:0]     req_word_id,
   input  logic                req_id_present,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [ID_W-1:0]     rsp_result_id,
   input  logic                rsp_id_ok,
   input  logic [HANDLE_W-1:0] rsp_result_handle,
   output int                  fail_count,
   output int                  pending_count
);

   localparam int ID_COUNT = ID_COUNT_DEF;

   typedef struct packed {
      logic [ID_W-1:0]     granted_id;
      logic                ok;
      logic [HANDLE_W-1:0] mapped_handle;
   } rid_result_type;

   // predicted allocator state
   logic [HANDLE_W-1:0] handle_map [ID_COUNT];
   logic [ID_W-1:0]     recycle_stack [ID_COUNT];
   int                  recycle_depth;
   int                  next_fresh_id;

   // responses owed by the block, oldest first
   rid_result_type results_due [$];
   int             rsp_seen;

   task automatic flag_error(input string msg);
      $display("[%0t] %s", $time, msg);
      fail_count++;
   endtask

   // apply one request to the predicted state and return its response
   function automatic rid_result_type predict_response(
      input logic [REQ_W-1:0]    kind,
      input logic [HANDLE_W-1:0] handle,
      input logic [ID_W-1:0]     id,
      input logic                present
   );
      rid_result_type res;
      res = '0;
      case (kind)
         REQ_ALLOC: begin
            if (handle != '0) begin
               // recycled ids first, then never-used ones
               if (recycle_depth > 0) begin
                  recycle_depth--;
                  res.granted_id = recycle_stack[recycle_depth];
                  res.ok = 1'b1;
               end else if (next_fresh_id < ID_COUNT) begin
                  res.granted_id = ID_W'(next_fresh_id);
                  next_fresh_id++;
                  res.ok = 1'b1;
               end
               if (res.ok)
                  handle_map[res.granted_id] = handle;
            end
         end
         REQ_RELEASE: begin
            if (handle != '0 && present) begin
               // map cleared only by its owner, push regardless of owner unless full
               if (handle_map[id] == handle)
                  handle_map[id] = '0;
               if (recycle_depth < ID_COUNT) begin
                  recycle_stack[recycle_depth] = id;
                  recycle_depth++;
               end
               res.ok = 1'b1;
            end
         end
         REQ_LOOKUP: begin
            res.mapped_handle = handle_map[id];
            res.ok = (handle_map[id] != '0);
         end
         default: ;
      endcase
      return res;
   endfunction

   // predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch_transfers
      rid_result_type want;
      if (reset) begin
         for (int i = 0; i < ID_COUNT; i++)
            handle_map[i] = '0;
         recycle_depth = 0;
         next_fresh_id = 0;
         results_due.delete();
         rsp_seen = 0;
      end else begin
         if (req_valid && req_ready)
            results_due.push_back(predict_response(req_type, req_entry_handle,
                                                   req_word_id, req_id_present));
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (results_due.size() == 0) begin
               flag_error($sformatf("response %0d arrived with nothing expected",
                                    rsp_seen));
            end else begin
               want = results_due.pop_front();
               if (rsp_result_id !== want.granted_id)
                  flag_error($sformatf("response %0d result_id: expected %0d, got %0d",
                                       rsp_seen, want.granted_id, rsp_result_id));
               if (rsp_id_ok !== want.ok)
                  flag_error($sformatf("response %0d id_ok: expected %0b, got %0b",
                                       rsp_seen, want.ok, rsp_id_ok));
               if (rsp_result_handle !== want.mapped_handle)
                  flag_error($sformatf("response %0d result_handle: expected %h, got %h",
                                       rsp_seen, want.mapped_handle, rsp_result_handle));
            end
         end
      end
      pending_count <= results_due.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the recycling id allocator with directed corner requests, a random
// mix of mostly well-formed allocate/release/lookup traffic, and a short
// closing burst of allocates and lookups; response checking is done by
// rid_grant_checker
// ----------------------------------------------------------------------------
module tb_top;
   import rid_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int ID_COUNT    = ID_COUNT_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 4;

   typedef struct {
      logic [REQ_W-1:0]    kind;
      logic [HANDLE_W-1:0] handle;
   } sent_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type = '0;
   logic [HANDLE_W-1:0] req_entry_handle = '0;
   logic [ID_W-1:0]     req_word_id = '0;
   logic                req_id_present = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ID_W-1:0]     rsp_result_id;
   logic                rsp_id_ok;
   logic [HANDLE_W-1:0] rsp_result_handle;

   int fail_count;
   int pending_count;

   // stimulus bookkeeping: ids granted so far and the handle each went to
   bit [HANDLE_W-1:0] granted_handle [ID_COUNT];
   logic [ID_W-1:0]   live_ids [$];
   sent_req_type      sent_reqs [$];
   bit                calm = 1'b0;

   int stall_left = 0;
   int ready_roll;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   recycling_id_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_entry_handle  (req_entry_handle),
      .req_word_id       (req_word_id),
      .req_id_present    (req_id_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_id     (rsp_result_id),
      .rsp_id_ok         (rsp_id_ok),
      .rsp_result_handle (rsp_result_handle)
   );

   rid_grant_checker grant_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_entry_handle  (req_entry_handle),
      .req_word_id       (req_word_id),
      .req_id_present    (req_id_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_id     (rsp_result_id),
      .rsp_id_ok         (rsp_id_ok),
      .rsp_result_handle (rsp_result_handle),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic logic [HANDLE_W-1:0] nonzero_handle();
      logic [HANDLE_W-1:0] h;
      h = $urandom;
      if (h == '0)
         h = 'h1;
      return h;
   endfunction

   // receiver side stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (calm || ready_roll < 60) begin
            rsp_ready <= 1'b1;
            stall_left <= $urandom_range(0, 5);
         end else if (ready_roll < 92) begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   // learn granted ids from responses so releases and lookups hit live ids
   always @(posedge clock) begin : track_grants
      sent_req_type done;
      if (!reset) begin
         if (req_valid && req_ready)
            sent_reqs.push_back(sent_req_type'{req_type, req_entry_handle});
         if (rsp_valid && rsp_ready && sent_reqs.size() > 0) begin
            done = sent_reqs.pop_front();
            if (done.kind == REQ_ALLOC && rsp_id_ok) begin
               granted_handle[rsp_result_id] = done.handle;
               live_ids.push_back(rsp_result_id);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one request transfer; valid is left high so back-to-back items stay high
   task automatic send_request(
      input logic [REQ_W-1:0]    kind,
      input logic [HANDLE_W-1:0] handle,
      input logic [ID_W-1:0]     id,
      input logic                present
   );
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_entry_handle <= handle;
      req_word_id      <= id;
      req_id_present   <= present;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold requests until every owed response has been returned
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int                  roll;
      int                  pick;
      int                  idx;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] h;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners on an empty allocator
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0, 1'b1);
      send_request(REQ_LOOKUP, 32'h1234_5678, 10'd1023, 1'b0);
      send_request(REQ_ALLOC, 32'h0, 10'd1023, 1'b1);
      send_request(REQ_ALLOC, 32'hFFFF_FFFF, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 32'h1, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 32'h8000_0000, 10'd512, 1'b1);
      send_request(REQ_LOOKUP, 32'h0, 10'd0, 1'b0);
      send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 10'd1023, 1'b1);
      // release ignored: id absent, then zero handle
      send_request(REQ_RELEASE, 32'h1, 10'd1, 1'b0);
      send_request(REQ_RELEASE, 32'h0, 10'd1, 1'b1);
      // foreign handle: map kept, id still pushed
      send_request(REQ_RELEASE, 32'h2, 10'd1, 1'b1);
      send_request(REQ_LOOKUP, 32'h0, 10'd1, 1'b1);
      // owner release pushes the same id a second time
      send_request(REQ_RELEASE, 32'h1, 10'd1, 1'b1);
      send_request(REQ_LOOKUP, 32'h0, 10'd1, 1'b1);
      send_request(REQ_ALLOC, 32'hA5A5_A5A5, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 32'h5A5A_5A5A, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 32'h0000_FFFF, 10'd0, 1'b0);
      // release of an id never granted
      send_request(REQ_RELEASE, 32'h5, 10'd1023, 1'b1);
      send_request(REQ_ALLOC, 32'hFFFF_0000, 10'd0, 1'b0);
      send_request(REQ_LOOKUP, 32'h0, 10'd1023, 1'b0);
      send_request(REQ_RELEASE, 32'hFFFF_FFFF, 10'd0, 1'b1);
      send_request(REQ_LOOKUP, 32'h0, 10'd0, 1'b1);
      wait_drained();

      // random mix, mostly well-formed alloc/release pairs
      for (int n = 0; n < 460; n++) begin
         calm = (n >= 180 && n < 260);
         if (n == 320)
            wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            pick = $urandom_range(0, 19);
            h = (pick == 0) ? '0 : (pick == 1) ? '1 : nonzero_handle();
            send_request(REQ_ALLOC, h, ID_W'($urandom), 1'($urandom));
         end else if (roll < 70 && live_ids.size() > 0) begin
            idx = $urandom_range(0, live_ids.size() - 1);
            id = live_ids[idx];
            live_ids.delete(idx);
            send_request(REQ_RELEASE, granted_handle[id], id, 1'b1);
         end else if (roll < 78) begin
            // foreign handle, double free or never-granted id
            send_request(REQ_RELEASE, nonzero_handle(), ID_W'($urandom), 1'b1);
         end else if (roll < 84) begin
            pick = $urandom_range(0, 1);
            if (pick == 1)
               send_request(REQ_RELEASE, '0, ID_W'($urandom), 1'($urandom));
            else
               send_request(REQ_RELEASE, $urandom, ID_W'($urandom), 1'b0);
         end else if (roll < 96) begin
            if (live_ids.size() > 0 && $urandom_range(0, 9) < 7)
               id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else
               id = ID_W'($urandom);
            send_request(REQ_LOOKUP, $urandom, id, 1'($urandom));
         end else begin
            send_request(REQ_UNKNOWN, $urandom, ID_W'($urandom), 1'($urandom));
         end
      end
      calm = 1'b0;
      wait_drained();

      // closing burst of pops and lookups
      repeat (8) send_request(REQ_ALLOC, nonzero_handle(), '0, 1'b0);
      repeat (8) send_request(REQ_LOOKUP, $urandom, ID_W'($urandom), 1'($urandom));
      wait_drained();

      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/rid_pkg.sv
sv/rid_ram.sv
sv/recycling_id_allocator.sv
bench/rid_grant_checker.sv
bench/tb_top.sv
